FILE: hdl/pbod_pkg.sv
package pbod_pkg;

   // Largest width or height the 13-bit size registers can hold
   localparam int CFG_DIM_MAX = 8191;
   localparam int DEF_MAX_WIDTH = 4096;
   localparam int DEF_MAX_HEIGHT = 4096;

   localparam int PAL_DEPTH = 256;
   localparam int PAL_AW = 8;
   localparam int COLOUR_W = 24;

   // Palette index layout: grey ramp first, then the 6x6x6 cube
   localparam logic [7:0] CUBE_BASE = 8'd40;
   localparam logic [7:0] CUBE_R_STRIDE = 8'd36;
   localparam logic [7:0] CUBE_G_STRIDE = 8'd6;
   localparam logic [10:0] LEVEL_SCALE = 11'd5;

   typedef enum logic [1:0] {
      FMT_FILL = 2'd0,
      FMT_1BPP = 2'd1,
      FMT_8BPP = 2'd2,
      FMT_NONE = 2'd3
   } fmt_type;

   typedef enum logic [1:0] {
      CSR_FORMAT = 2'd0,
      CSR_WIDTH  = 2'd1,
      CSR_HEIGHT = 2'd2
   } csr_idx_type;

   typedef enum logic {
      OP_PALETTE = 1'b0,
      OP_PIXEL   = 1'b1
   } op_type;

   // Bayer 4x4 threshold turned into a channel offset, indexed by {row[1:0], col[1:0]}
   localparam logic [5:0] STEP_TABLE [16] = '{
      6'd1,  6'd37, 6'd4,  6'd34,
      6'd47, 6'd14, 6'd50, 6'd17,
      6'd8,  6'd30, 6'd11, 6'd27,
      6'd40, 6'd21, 6'd43, 6'd24
   };

   function automatic logic [7:0] dither_index(logic [1:0] row2, logic [1:0] col2,
                                               logic [COLOUR_W-1:0] clr);
      logic [7:0]  red;
      logic [7:0]  grn;
      logic [7:0]  blu;
      logic [5:0]  step;
      logic [10:0] rp;
      logic [10:0] gp;
      logic [10:0] bp;
      logic [7:0]  idx;
      red = clr[23:16];
      grn = clr[15:8];
      blu = clr[7:0];
      step = STEP_TABLE[{row2, col2}];
      rp = (11'(red) + 11'(step)) * LEVEL_SCALE;
      gp = (11'(grn) + 11'(step)) * LEVEL_SCALE;
      bp = (11'(blu) + 11'(step)) * LEVEL_SCALE;
      if (red[7:4] == grn[7:4] && grn[7:4] == blu[7:4]) begin
         idx = {4'h0, red[7:4]};
      end else begin
         idx = CUBE_BASE + 8'(rp[10:8]) * CUBE_R_STRIDE
               + 8'(gp[10:8]) * CUBE_G_STRIDE + 8'(bp[10:8]);
      end
      return idx;
   endfunction

endpackage

FILE: hdl/palette_bitmap_ordered_dither_unit.sv
// Channel   Dir  Payload (low bit up)                                   Handshake
// req       in   tdata: slot[7:0] colour[31:8] byte[39:32];             tvalid/tready
//                tuser: opcode[0] start_of_image[1]
// rsp       out  tdata: pixel_index[7:0]; tuser: end_of_row[0]          tvalid/tready
//                end_of_image[1]; tlast: last word of this request
// csr       in   index, wdata (format, width, height)                   valid/ready
//
// One pixel word per cycle sustained while rsp is ready. Fill and 8 bpp words yield
// one pixel each; a 1 bpp word keeps req_tready low while it yields its further pixels
// (up to eight in all), since every pixel costs one read of the single palette port.
// Each pixel goes through the palette read, then dither into the output register.
// Reset is synchronous; it clears position, sets the format to 8 bpp and both sizes to 1, but not the palette.
// A stalled rsp fills the read stage and only then drops req_tready.
module palette_bitmap_ordered_dither_unit import pbod_pkg::*; #(
   parameter int MAX_WIDTH = DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // palette_slot, palette_colour, source_byte
   input  logic [1:0]  req_tuser,   // opcode, start_of_image
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // pixel_index
   output logic [1:0]  rsp_tuser,   // end_of_row, end_of_image
   output logic        rsp_tlast,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [12:0] csr_wdata
);

   localparam int EFF_W_MAX = (MAX_WIDTH < CFG_DIM_MAX) ? MAX_WIDTH : CFG_DIM_MAX;
   localparam int EFF_H_MAX = (MAX_HEIGHT < CFG_DIM_MAX) ? MAX_HEIGHT : CFG_DIM_MAX;
   localparam int WW = $clog2(EFF_W_MAX + 1);
   localparam int CW = $clog2(EFF_W_MAX);
   localparam int RW = $clog2(EFF_H_MAX + 1);

   // Input fields
   logic [PAL_AW-1:0]   req_slot;
   logic [COLOUR_W-1:0] req_colour;
   logic [7:0]          req_byte;
   op_type              req_op;
   logic                req_sof;
   logic                req_acc;

   assign req_slot   = req_tdata[7:0];
   assign req_colour = req_tdata[31:8];
   assign req_byte   = req_tdata[39:32];
   assign req_op     = op_type'(req_tuser[0]);
   assign req_sof    = req_tuser[1];

   // Configuration
   fmt_type         fmt_ff;
   logic [WW-1:0]   width_ff;
   logic [RW-1:0]   height_ff;
   logic [WW-1:0]   width_wr;
   logic [RW-1:0]   height_wr;

   // Position and 1 bpp hold
   logic [CW-1:0]   col_ff, col_in;
   logic [RW-1:0]   row_ff, row_in;
   logic            busy_ff, busy_in;
   logic [2:0]      bits_ff, bits_in;
   logic [7:0]      shift_ff, shift_in;

   // Read stage
   logic            p1_valid_ff;
   logic [1:0]      p1_col_ff;
   logic [1:0]      p1_row_ff;
   logic            p1_eor_ff;
   logic            p1_eoi_ff;
   logic            p1_last_ff;
   logic [COLOUR_W-1:0] rd_data_ff;

   // Output register
   logic            rsp_valid_ff;
   logic [7:0]      rsp_index_ff;
   logic            rsp_eor_ff;
   logic            rsp_eoi_ff;
   logic            rsp_last_ff;

   logic [COLOUR_W-1:0] pal_mem [PAL_DEPTH];

   logic            adv1;
   logic            adv2;
   logic            issue;
   logic            fire;
   logic            pos_en;
   logic [PAL_AW-1:0] pix_addr;
   logic [CW-1:0]   c0;
   logic [RW-1:0]   r0;
   logic [CW-1:0]   pos_col;
   logic [RW-1:0]   pos_row;
   logic [WW-1:0]   col_p1;
   logic            eor;
   logic            eoi;
   logic            run_end;

   assign adv2 = !rsp_valid_ff || rsp_tready;
   assign adv1 = !p1_valid_ff || adv2;
   assign req_tready = adv1 && !busy_ff;
   assign req_acc = req_tvalid && req_tready;
   assign csr_ready = 1'b1;

   assign c0 = req_sof ? '0 : col_ff;
   assign r0 = req_sof ? '0 : row_ff;

   // Clamp sizes at write time
   always_comb begin
      if (csr_wdata == '0) begin
         width_wr = WW'(1);
      end else if (32'(csr_wdata) > 32'(MAX_WIDTH)) begin
         width_wr = WW'(EFF_W_MAX);
      end else begin
         width_wr = WW'(csr_wdata);
      end
      if (csr_wdata == '0) begin
         height_wr = RW'(1);
      end else if (32'(csr_wdata) > 32'(MAX_HEIGHT)) begin
         height_wr = RW'(EFF_H_MAX);
      end else begin
         height_wr = RW'(csr_wdata);
      end
   end

   // Pixel issue: pick position and palette address, advance position
   always_comb begin
      issue    = 1'b0;
      pix_addr = '0;
      pos_col  = col_ff;
      pos_row  = row_ff;
      if (busy_ff) begin
         issue    = 1'b1;
         pix_addr = PAL_AW'(shift_ff[7]);
      end else if (req_acc && req_op == OP_PIXEL) begin
         pos_col = c0;
         pos_row = r0;
         if (fmt_ff != FMT_NONE) begin
            // close a row left open by a narrowed width
            if (r0 < height_ff && WW'(c0) >= width_ff) begin
               pos_col = '0;
               pos_row = r0 + RW'(1);
            end
            if (pos_row < height_ff) begin
               issue = 1'b1;
               case (fmt_ff)
                  FMT_8BPP: pix_addr = req_byte;
                  FMT_1BPP: pix_addr = PAL_AW'(req_byte[7]);
                  default:  pix_addr = '0;
               endcase
            end
         end
      end

      col_p1 = WW'(pos_col) + WW'(1);
      eor = col_p1 >= width_ff;
      eoi = eor && ((pos_row + RW'(1)) >= height_ff);
      if (busy_ff) begin
         run_end = eor || bits_ff == 3'd7;
      end else begin
         run_end = fmt_ff != FMT_1BPP || eor;
      end

      col_in = pos_col;
      row_in = pos_row;
      if (issue) begin
         col_in = eor ? '0 : CW'(col_p1);
         row_in = eor ? pos_row + RW'(1) : pos_row;
      end

      busy_in  = busy_ff;
      bits_in  = bits_ff;
      shift_in = shift_ff;
      if (busy_ff) begin
         bits_in  = bits_ff + 3'd1;
         shift_in = {shift_ff[6:0], 1'b0};
         busy_in  = !run_end;
      end else if (issue && fmt_ff == FMT_1BPP) begin
         bits_in  = 3'd1;
         shift_in = {req_byte[6:0], 1'b0};
         busy_in  = !run_end;
      end
   end

   assign fire = issue && adv1;
   assign pos_en = busy_ff ? adv1 : (req_acc && req_op == OP_PIXEL);

   // Palette memory: write port from palette words, one registered read port
   always_ff @(posedge clock) begin
      if (req_acc && req_op == OP_PALETTE) begin
         pal_mem[req_slot] <= req_colour;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rd_data_ff <= pal_mem[pix_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fmt_ff    <= FMT_8BPP;
         width_ff  <= WW'(1);
         height_ff <= RW'(1);
      end else if (csr_valid && csr_ready) begin
         unique case (csr_idx_type'(csr_index))
            CSR_FORMAT: fmt_ff    <= fmt_type'(csr_wdata[1:0]);
            CSR_WIDTH:  width_ff  <= width_wr;
            CSR_HEIGHT: height_ff <= height_wr;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff  <= '0;
         row_ff  <= '0;
         busy_ff <= 1'b0;
         bits_ff <= '0;
      end else if (pos_en) begin
         col_ff  <= col_in;
         row_ff  <= row_in;
         busy_ff <= busy_in;
         bits_ff <= bits_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pos_en) begin
         shift_ff <= shift_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff <= 1'b0;
      end else if (adv1) begin
         p1_valid_ff <= issue;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         p1_col_ff  <= pos_col[1:0];
         p1_row_ff  <= pos_row[1:0];
         p1_eor_ff  <= eor;
         p1_eoi_ff  <= eoi;
         p1_last_ff <= run_end;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv2) begin
         rsp_valid_ff <= p1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv2 && p1_valid_ff) begin
         rsp_index_ff <= dither_index(p1_row_ff, p1_col_ff, rd_data_ff);
         rsp_eor_ff   <= p1_eor_ff;
         rsp_eoi_ff   <= p1_eoi_ff;
         rsp_last_ff  <= p1_last_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_index_ff;
   assign rsp_tuser  = {rsp_eoi_ff, rsp_eor_ff};
   assign rsp_tlast  = rsp_last_ff;

   a_busy_1bpp: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> fmt_ff == FMT_1BPP)
      else $error("1 bpp hold active in another format");

   a_busy_blocks_req: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> !req_tready)
      else $error("new word taken while a 1 bpp word is unfinished");

   a_busy_in_row: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> WW'(col_ff) < width_ff)
      else $error("1 bpp hold past end of row");

   a_eoi_closes: assert property (@(posedge clock) disable iff (reset)
      p1_valid_ff && p1_eoi_ff |-> p1_eor_ff && p1_last_ff)
      else $error("end of image without end of row and end of run");

   a_read_hold: assert property (@(posedge clock) disable iff (reset)
      p1_valid_ff && !adv2 |=> p1_valid_ff && $stable(rd_data_ff) && $stable(p1_last_ff))
      else $error("read stage lost data under stall");

endmodule

FILE: tb/palette_bitmap_ordered_dither_unit_test.sv
`timescale 1ns / 1ps

module palette_bitmap_ordered_dither_unit_test import pbod_pkg::*;;

   localparam int CYCLE_LIMIT = 1000000;
   localparam int SETTLE_CYCLES = 12;
   localparam int RANDOM_DATA_WORDS = 110;
   localparam int FRAME_WORD_CAP = 48;
   localparam int SCRIPT_LEN = 36;

   // Bayer levels, indexed by {row[1:0], col[1:0]}
   localparam int BAYER_LEVEL [16] = '{0, 11, 1, 10, 14, 4, 15, 5, 2, 9, 3, 8, 12, 6, 13, 7};

   typedef struct packed {
      logic [7:0] index;
      logic       eor;
      logic       eoi;
      logic       last;
   } pixel_type;

   typedef enum logic [1:0] {
      PREDICTED = 2'd0,
      SILENT    = 2'd1,
      TYPED     = 2'd2
   } check_type;

   typedef enum logic [1:0] {
      ROW_WORD = 2'd0,
      ROW_CSR  = 2'd1
   } row_kind_type;

   typedef struct packed {
      row_kind_type kind;
      csr_idx_type  reg_idx;
      logic [12:0]  value;
      op_type       op;
      logic [7:0]   slot;
      logic [23:0]  colour;
      logic [7:0]   sbyte;
      logic         soi;
      check_type    check;
      pixel_type    px;
   } script_row_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [39:0] req_tdata;
   logic [1:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [7:0]  rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        rsp_tlast;
   logic        csr_valid;
   logic        csr_ready;
   logic [1:0]  csr_index;
   logic [12:0] csr_wdata;

   // Predictor state
   logic [23:0] pal_colour [256];
   int          pos_col;
   int          pos_row;
   fmt_type     cfg_fmt;
   logic [12:0] cfg_width;
   logic [12:0] cfg_height;

   pixel_type fresh_pixels [$];
   pixel_type expected_pixels [$];
   pixel_type want_px;

   bit req_busy = 1'b0;
   bit sink_busy = 1'b0;
   int mismatches = 0;
   int pixel_words = 0;
   int data_words = 0;
   int palette_words = 0;
   int csr_writes = 0;
   int phases = 0;
   int cycle_count = 0;

   // Directed words: palette extremes, grey and cube colours, the finished image,
   // saturated and zero sizes, a row closed after the width drops, fill, 1 bpp with a
   // word cut short at the row end, and the unused format.
   script_row_type script_rows [SCRIPT_LEN] = '{
      '{ROW_WORD, CSR_FORMAT, 13'd0, OP_PALETTE, 8'h00, 24'h000000, 8'h00, 1'b0, SILENT, '0},
      '{ROW_WORD, CSR_FORMAT, 13'd0, OP_PALETTE, 8'hFF, 24'hFFFFFF, 8'hFF, 1'b1, SILENT, '0},
      '{ROW_WORD, CSR_FORMAT, 13'd0, OP_PALETTE, 8'h01, 24'h0F1F2F, 8'h00, 1'b0, SILENT, '0},
      '{ROW_WORD, CSR_FORMAT, 13'd0, OP_PALETTE, 8'h02, 24'hFF0000, 8'h00, 1'b0, SILENT, '0},
      '{ROW_WORD, CSR_FORMAT, 13'd0, OP_PALETTE, 8'h03, 24'h00FF80, 8'h00, 1'b0, SILENT, '0},
      '{ROW_WORD, CSR_FORMAT, 13'd0, OP_PALETTE, 8'h04, 24'h7F8081, 8'h00, 1'b0, SILENT, '0},
      '{ROW_WORD, CSR_FORMAT, 13'd0, OP_PALETTE, 8'h05, 24'h808080, 8'h00, 1'b0, SILENT, '0},
      '{ROW_WORD, CSR_FORMAT, 13'd0, OP_PIXEL, 8'h00, 24'h000000, 8'h00, 1'b1, TYPED,
        '{8'd0, 1'b1, 1'b1, 1'b1}},
      '{ROW_WORD, CSR_FORMAT, 13'd0, OP_PIXEL, 8'h00, 24'h000000, 8'h00, 1'b0, SILENT, '0},
      '{ROW_WORD, CSR_FORMAT, 13'd0, OP_PIXEL, 8'h00, 24'h000000, 8'hFF, 1'b1, TYPED,
        '{8'd15, 1'b1, 1'b1, 1'b1}},
      '{ROW_WORD, CSR_FORMAT, 13'd0, OP_PIXEL, 8'h00, 24'h000000, 8'h05, 1'b1, TYPED,
        '{8'd8, 1'b1, 1'b1, 1'b1}},
      '{ROW_WORD, CSR_FORMAT, 13'd0, OP_PIXEL, 8'h00, 24'h000000, 8'h02, 1'b1, PREDICTED, '0},
      '{ROW_WORD, CSR_FORMAT, 13'd0, OP_PIXEL, 8'h00, 24'h000000, 8'h03, 1'b1, PREDICTED, '0},
      '{ROW_WORD, CSR_FORMAT, 13'd0, OP_PIXEL, 8'h00, 24'h000000, 8'h04, 1'b1, PREDICTED, '0},
      '{ROW_WORD, CSR_FORMAT, 13'd0, OP_PIXEL, 8'h00, 24'h000000, 8'h01, 1'b1, PREDICTED, '0},
      '{ROW_CSR, CSR_WIDTH, 13'd8191, OP_PALETTE, 8'h00, 24'h000000, 8'h00, 1'b0, SILENT, '0},
      '{ROW_CSR, CSR_HEIGHT, 13'd8191, OP_PALETTE, 8'h00, 24'h000000, 8'h00, 1'b0, SILENT, '0},
      '{ROW_WORD, CSR_FORMAT, 13'd0, OP_PIXEL, 8'h00, 24'h000000, 8'h04, 1'b1, PREDICTED, '0},
      '{ROW_WORD, CSR_FORMAT, 13'd0, OP_PIXEL, 8'h00, 24'h000000, 8'h02, 1'b0, PREDICTED, '0},
      '{ROW_CSR, CSR_WIDTH, 13'd0, OP_PALETTE, 8'h00, 24'h000000, 8'h00, 1'b0, SILENT, '0},
      '{ROW_WORD, CSR_FORMAT, 13'd0, OP_PIXEL, 8'h00, 24'h000000, 8'h04, 1'b0, PREDICTED, '0},
      '{ROW_CSR, CSR_FORMAT, 13'(FMT_FILL), OP_PALETTE, 8'h00, 24'h000000, 8'h00, 1'b0,
        SILENT, '0},
      '{ROW_CSR, CSR_WIDTH, 13'd3, OP_PALETTE, 8'h00, 24'h000000, 8'h00, 1'b0, SILENT, '0},
      '{ROW_CSR, CSR_HEIGHT, 13'd0, OP_PALETTE, 8'h00, 24'h000000, 8'h00, 1'b0, SILENT, '0},
      '{ROW_WORD, CSR_FORMAT, 13'd0, OP_PIXEL, 8'h00, 24'h000000, 8'hAB, 1'b1, TYPED,
        '{8'd0, 1'b0, 1'b0, 1'b1}},
      '{ROW_WORD, CSR_FORMAT, 13'd0, OP_PIXEL, 8'h00, 24'h000000, 8'h00, 1'b0, TYPED,
        '{8'd0, 1'b0, 1'b0, 1'b1}},
      '{ROW_WORD, CSR_FORMAT, 13'd0, OP_PIXEL, 8'h00, 24'h000000, 8'hFF, 1'b0, TYPED,
        '{8'd0, 1'b1, 1'b1, 1'b1}},
      '{ROW_WORD, CSR_FORMAT, 13'd0, OP_PIXEL, 8'h00, 24'h000000, 8'h55, 1'b0, SILENT, '0},
      '{ROW_CSR, CSR_FORMAT, 13'(FMT_1BPP), OP_PALETTE, 8'h00, 24'h000000, 8'h00, 1'b0,
        SILENT, '0},
      '{ROW_CSR, CSR_WIDTH, 13'd10, OP_PALETTE, 8'h00, 24'h000000, 8'h00, 1'b0, SILENT, '0},
      '{ROW_WORD, CSR_FORMAT, 13'd0, OP_PIXEL, 8'h00, 24'h000000, 8'hA5, 1'b1, PREDICTED, '0},
      '{ROW_WORD, CSR_FORMAT, 13'd0, OP_PIXEL, 8'h00, 24'h000000, 8'hFF, 1'b0, PREDICTED, '0},
      '{ROW_WORD, CSR_FORMAT, 13'd0, OP_PIXEL, 8'h00, 24'h000000, 8'h00, 1'b0, SILENT, '0},
      '{ROW_CSR, CSR_FORMAT, 13'h1FFF, OP_PALETTE, 8'h00, 24'h000000, 8'h00, 1'b0, SILENT, '0},
      '{ROW_WORD, CSR_FORMAT, 13'd0, OP_PIXEL, 8'h00, 24'h000000, 8'h12, 1'b1, SILENT, '0},
      '{ROW_CSR, CSR_FORMAT, 13'(FMT_8BPP), OP_PALETTE, 8'h00, 24'h000000, 8'h00, 1'b0,
        SILENT, '0}
   };

   palette_bitmap_ordered_dither_unit i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   function automatic int eff_size(logic [12:0] raw, int cap);
      if (raw == 13'd0) return 1;
      return (int'(raw) > cap) ? cap : int'(raw);
   endfunction

   function automatic logic [7:0] dithered_index(int col, int row, logic [23:0] clr);
      int lvl;
      int step;
      int red_l;
      int grn_l;
      int blu_l;
      // equal top nibbles land on the grey ramp
      if (clr[23:20] == clr[15:12] && clr[15:12] == clr[7:4]) return {4'h0, clr[23:20]};
      lvl = BAYER_LEVEL[(row % 4) * 4 + (col % 4)];
      step = (lvl * 49 + 7) / 15 + 1;
      red_l = ((int'(clr[23:16]) + step) * 5) >> 8;
      grn_l = ((int'(clr[15:8]) + step) * 5) >> 8;
      blu_l = ((int'(clr[7:0]) + step) * 5) >> 8;
      return 8'(40 + 36 * red_l + 6 * grn_l + blu_l);
   endfunction

   function automatic logic [23:0] any_colour();
      logic [3:0] n;
      n = 4'($urandom);
      case ($urandom_range(0, 9))
         0, 1, 2: return {n, 4'($urandom), n, 4'($urandom), n, 4'($urandom)};
         3: return ($urandom_range(0, 1) != 0) ? 24'hFFFFFF : 24'h000000;
         4: return {n, 4'($urandom), n, 4'($urandom), n + 4'd1, 4'($urandom)};
         default: return 24'($urandom);
      endcase
   endfunction

   task automatic emit_pixel(input logic [23:0] clr, input int w, input int h,
                             output bit row_done);
      pixel_type px;
      row_done = (pos_col + 1 >= w);
      px.index = dithered_index(pos_col, pos_row, clr);
      px.eor = row_done;
      px.eoi = row_done && (pos_row + 1 >= h);
      px.last = 1'b0;
      fresh_pixels.push_back(px);
      if (row_done) begin
         pos_col = 0;
         pos_row++;
      end else begin
         pos_col++;
      end
   endtask

   task automatic render_word(input op_type op, input logic [7:0] slot,
                              input logic [23:0] colour, input logic [7:0] sbyte,
                              input logic soi);
      int w;
      int h;
      int bit_pos;
      bit row_done;
      pixel_type px;
      fresh_pixels.delete();
      if (op == OP_PALETTE) begin
         pal_colour[slot] = colour;
         return;
      end
      w = eff_size(cfg_width, DEF_MAX_WIDTH);
      h = eff_size(cfg_height, DEF_MAX_HEIGHT);
      if (soi) begin
         pos_col = 0;
         pos_row = 0;
      end
      if (cfg_fmt == FMT_NONE) return;
      // width dropped under the column: close the row first
      if (pos_row < h && pos_col >= w) begin
         pos_col = 0;
         pos_row++;
      end
      if (pos_row >= h) return;
      case (cfg_fmt)
         FMT_FILL: emit_pixel(pal_colour[0], w, h, row_done);
         FMT_8BPP: emit_pixel(pal_colour[sbyte], w, h, row_done);
         default: begin
            row_done = 1'b0;
            for (bit_pos = 7; bit_pos >= 0 && !row_done; bit_pos--)
               emit_pixel(sbyte[bit_pos] ? pal_colour[1] : pal_colour[0], w, h, row_done);
         end
      endcase
      px = fresh_pixels.pop_back();
      px.last = 1'b1;
      fresh_pixels.push_back(px);
   endtask

   task automatic report_mismatch(input string what);
      mismatches++;
      $display("[%0t] pixel word %0d: %s", $time, pixel_words, what);
   endtask

   task automatic drain_pixels();
      req_tvalid = 1'b0;
      while (expected_pixels.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(input csr_idx_type idx, input logic [12:0] value);
      drain_pixels();
      csr_index = idx;
      csr_wdata = value;
      csr_valid = 1'b1;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid = 1'b0;
      case (idx)
         CSR_FORMAT: cfg_fmt = fmt_type'(value[1:0]);
         CSR_WIDTH: cfg_width = value;
         default: cfg_height = value;
      endcase
      csr_writes++;
   endtask

   task automatic send_word(input op_type op, input logic [7:0] slot,
                            input logic [23:0] colour, input logic [7:0] sbyte,
                            input logic soi, input check_type check,
                            input pixel_type typed);
      int gap;
      gap = req_busy ? 0 : $urandom_range(0, 16);
      if (gap > 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tdata = {sbyte, colour, slot};
      req_tuser = {soi, op};
      req_tvalid = 1'b1;
      // queue on presentation so the expected pixels are in place before the word is taken
      render_word(op, slot, colour, sbyte, soi);
      case (check)
         SILENT: ;
         TYPED: expected_pixels.push_back(typed);
         default: foreach (fresh_pixels[i]) expected_pixels.push_back(fresh_pixels[i]);
      endcase
      if (op == OP_PIXEL) data_words++;
      else palette_words++;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   task automatic run_frame_phase();
      logic [12:0] w;
      logic [12:0] h;
      fmt_type f;
      int per_row;
      int n_words;
      int k;
      bit start_frame;
      req_busy = ($urandom_range(0, 3) == 0);
      sink_busy = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 9))
         0: f = FMT_NONE;
         1, 2: f = FMT_FILL;
         3, 4, 5: f = FMT_1BPP;
         default: f = FMT_8BPP;
      endcase
      case ($urandom_range(0, 19))
         0: w = 13'd0;
         1: w = 13'd4096;
         2: w = 13'd8191;
         3: w = 13'($urandom_range(4097, 8190));
         4, 5: w = 13'($urandom_range(13, 64));
         default: w = 13'($urandom_range(1, 12));
      endcase
      case ($urandom_range(0, 19))
         0: h = 13'd0;
         1: h = 13'd4096;
         2: h = 13'd8191;
         default: h = 13'($urandom_range(1, 5));
      endcase
      // skipped writes keep the old setting and may leave the column past a new width
      if (phases == 0 || $urandom_range(0, 4) != 0) write_csr(CSR_FORMAT, {11'($urandom), f});
      if (phases == 0 || $urandom_range(0, 4) != 0) write_csr(CSR_WIDTH, w);
      if (phases == 0 || $urandom_range(0, 4) != 0) write_csr(CSR_HEIGHT, h);
      per_row = eff_size(cfg_width, DEF_MAX_WIDTH);
      if (cfg_fmt == FMT_1BPP) per_row = (per_row + 7) / 8;
      n_words = per_row * eff_size(cfg_height, DEF_MAX_HEIGHT);
      if (n_words > FRAME_WORD_CAP) n_words = FRAME_WORD_CAP;
      n_words += $urandom_range(0, 3);
      start_frame = ($urandom_range(0, 4) != 0);
      for (k = 0; k < n_words; k++) begin
         case ($urandom_range(0, 49))
            0, 1: send_word(OP_PALETTE, 8'($urandom), any_colour(), 8'($urandom),
                            1'($urandom), PREDICTED, '0);
            2: drain_pixels();
            default: send_word(OP_PIXEL, 8'($urandom), 24'($urandom), 8'($urandom),
                               (k == 0) ? start_frame : ($urandom_range(0, 29) == 0),
                               PREDICTED, '0);
         endcase
      end
      phases++;
   endtask

   // Result sink: random stall before each word, none in busy phases
   initial begin : pixel_sink
      int hold;
      rsp_tready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         hold = sink_busy ? 0 : $urandom_range(0, 16);
         if (hold > 0) begin
            rsp_tready = 1'b0;
            repeat (hold) @(negedge clock);
         end
         rsp_tready = 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         @(negedge clock);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         pixel_words++;
         if (expected_pixels.size() == 0) begin
            report_mismatch($sformatf("unexpected word, index %0d", rsp_tdata));
         end else begin
            want_px = expected_pixels.pop_front();
            if (rsp_tdata !== want_px.index)
               report_mismatch($sformatf("pixel_index %0d, want %0d", rsp_tdata, want_px.index));
            if (rsp_tuser[0] !== want_px.eor)
               report_mismatch($sformatf("end_of_row %b, want %b", rsp_tuser[0], want_px.eor));
            if (rsp_tuser[1] !== want_px.eoi)
               report_mismatch($sformatf("end_of_image %b, want %b", rsp_tuser[1], want_px.eoi));
            if (rsp_tlast !== want_px.last)
               report_mismatch($sformatf("last_of_run %b, want %b", rsp_tlast, want_px.last));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d pixel words still owed",
                  cycle_count, expected_pixels.size());
         $display("*** FAILED ***");
         $finish;
      end
   end

   initial begin
      int r;
      int s;
      int base_words;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = '0;
      csr_valid = 1'b0;
      csr_index = CSR_FORMAT;
      csr_wdata = '0;
      pos_col = 0;
      pos_row = 0;
      cfg_fmt = FMT_8BPP;
      cfg_width = 13'd1;
      cfg_height = 13'd1;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      for (r = 0; r < SCRIPT_LEN; r++) begin
         if (script_rows[r].kind == ROW_CSR)
            write_csr(script_rows[r].reg_idx, script_rows[r].value);
         else
            send_word(script_rows[r].op, script_rows[r].slot, script_rows[r].colour,
                      script_rows[r].sbyte, script_rows[r].soi, script_rows[r].check,
                      script_rows[r].px);
      end

      // fill every palette slot so any source byte may be read from here on
      req_busy = ($urandom_range(0, 1) != 0);
      for (s = 0; s < 256; s++)
         send_word(OP_PALETTE, 8'(s), any_colour(), 8'($urandom), 1'($urandom), PREDICTED, '0);

      base_words = data_words;
      while (data_words - base_words < RANDOM_DATA_WORDS) run_frame_phase();

      drain_pixels();
      $display("Sent %0d source words and %0d palette writes over %0d random setting phases",
               data_words, palette_words, phases);
      $display("Made %0d register writes and checked %0d pixel words, %0d mismatches",
               csr_writes, pixel_words, mismatches);
      if (mismatches == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

FILE: palette_bitmap_ordered_dither_unit.f
hdl/pbod_pkg.sv
hdl/palette_bitmap_ordered_dither_unit.sv
tb/palette_bitmap_ordered_dither_unit_test.sv
